>>> src/prp_pkg.sv
package prp_pkg;

	localparam int PRP_MAX_RECTS = 64;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int CFG_W     = 7;
	localparam int IDX_W     = 6;
	localparam int FLAGS_W   = 4;
	localparam int RECT_W    = 4 * COORD_W;

	// stream word widths, padded to whole bytes
	localparam int S_FIELDS_W = IDX_W + 6 * COORD_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 2 * COORD_W + FLAGS_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	// request kinds carried on tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// hit flag bit positions
	localparam int HIT_LEFT  = 0;
	localparam int HIT_RIGHT = 1;
	localparam int HIT_LOW   = 2;
	localparam int HIT_HIGH  = 3;

	// one table entry, min x in the lowest bits
	typedef struct packed {
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] min_x;
	} rect_t;

endpackage

>>> src/prp_ram.sv
module prp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/point_rect_pushout.sv
// Resolves a point against a table of up to MAX_RECTS axis-aligned rectangles.
// A load word (tuser = 0) writes one table entry; an index at or past MAX_RECTS
// is dropped and a load returns nothing. A query word (tuser = 1) walks entries
// 0 .. active_rects-1 (saturated at MAX_RECTS); each entry that strictly
// contains the current point pushes it onto its nearest edge (left over right,
// low over high, x over y on ties), and the final point with the OR of the edges
// hit comes out as one word. One table read and one shared subtract/compare
// unit serve the walk: each entry is read, its edge distances are registered in
// ST_DIFF and the push is decided in ST_DECIDE, entry after entry, because
// each entry needs the point left by the one before. Loads can be taken while
// a result waits on the output; a query finishes only when the output is free.
// Entries a query reads must have been loaded first.
module point_rect_pushout
	import prp_pkg::*;
#(
	parameter int MAX_RECTS = PRP_MAX_RECTS
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,      // active_rects

	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// rect_index, rect_min_x, rect_max_x, rect_min_y, rect_max_y, point_x, point_y
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tuser,   // req_type

	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata    // out_x, out_y, hit_flags
);

	localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int NW = (CW > CFG_W) ? CW : CFG_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIFF,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	state_t                     state_q;
	logic [CFG_W-1:0]           active_q;
	logic signed [COORD_W-1:0]  px_q, py_q;
	logic [FLAGS_W-1:0]         flags_q;
	logic [CW-1:0]              cnt_q, idx_q;
	logic signed [DIFF_W-1:0]   dl_q, dr_q, dlo_q, dhi_q;
	rect_t                      rect_q;
	logic signed [COORD_W-1:0]  out_x_q, out_y_q;
	logic [FLAGS_W-1:0]         out_flags_q;
	logic                       out_valid_q;

	logic                       accept;
	logic [IDX_W-1:0]           in_index;
	rect_t                      in_rect;
	logic signed [COORD_W-1:0]  in_px, in_py;
	logic [NW-1:0]              act_ext, act_sat;
	logic [CW-1:0]              idx_nxt;
	logic                       last_rect;

	logic                       ram_we, ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [RECT_W-1:0]          ram_rdata;
	rect_t                      rd_rect;

	logic signed [DIFF_W-1:0]   dl_d, dr_d, dlo_d, dhi_d;
	logic                       contained, go_right, go_high, along_y;
	logic signed [DIFF_W-1:0]   xd, yd;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;

	assign in_index = s_axis_tdata[IDX_W-1:0];
	assign in_rect  = rect_t'(s_axis_tdata[IDX_W +: RECT_W]);
	assign in_px    = s_axis_tdata[IDX_W + RECT_W +: COORD_W];
	assign in_py    = s_axis_tdata[IDX_W + RECT_W + COORD_W +: COORD_W];

	assign act_ext = NW'(active_q);
	assign act_sat = (act_ext > NW'(MAX_RECTS)) ? NW'(MAX_RECTS) : act_ext;

	assign idx_nxt   = idx_q + CW'(1);
	assign last_rect = (idx_nxt == cnt_q);

	// table write straight from the input word
	assign ram_we = accept && (s_axis_tuser == REQ_LOAD)
		&& ({26'd0, in_index} < 32'(MAX_RECTS));
	assign ram_re = (accept && (s_axis_tuser == REQ_QUERY))
		|| ((state_q == ST_DECIDE) && !last_rect);
	assign ram_raddr = (state_q == ST_IDLE) ? '0 : AW'(idx_nxt);

	prp_ram #(
		.WIDTH(RECT_W),
		.DEPTH(MAX_RECTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(in_index)),
		.wdata(RECT_W'(in_rect)),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_rect = rect_t'(ram_rdata);

	// edge distances, one bit wider so they never wrap
	assign dl_d  = {px_q[COORD_W-1], px_q} - {rd_rect.min_x[COORD_W-1], rd_rect.min_x};
	assign dr_d  = {rd_rect.max_x[COORD_W-1], rd_rect.max_x} - {px_q[COORD_W-1], px_q};
	assign dlo_d = {py_q[COORD_W-1], py_q} - {rd_rect.min_y[COORD_W-1], rd_rect.min_y};
	assign dhi_d = {rd_rect.max_y[COORD_W-1], rd_rect.max_y} - {py_q[COORD_W-1], py_q};

	assign contained = !dl_q[DIFF_W-1] && (dl_q != '0)
		&& !dr_q[DIFF_W-1] && (dr_q != '0)
		&& !dlo_q[DIFF_W-1] && (dlo_q != '0)
		&& !dhi_q[DIFF_W-1] && (dhi_q != '0);
	assign go_right = (dr_q < dl_q);
	assign go_high  = (dlo_q > dhi_q);
	assign xd       = go_right ? dr_q : dl_q;
	assign yd       = go_high ? dhi_q : dlo_q;
	assign along_y  = (xd > yd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			// a finishing query refills the output itself
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && (s_axis_tuser == REQ_QUERY)) begin
						px_q    <= in_px;
						py_q    <= in_py;
						flags_q <= '0;
						cnt_q   <= CW'(act_sat);
						idx_q   <= '0;
						state_q <= (act_sat == '0) ? ST_FINISH : ST_DIFF;
					end
				end
				ST_DIFF: begin
					dl_q    <= dl_d;
					dr_q    <= dr_d;
					dlo_q   <= dlo_d;
					dhi_q   <= dhi_d;
					rect_q  <= rd_rect;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (contained) begin
						if (along_y) begin
							if (go_high) begin
								py_q              <= rect_q.max_y;
								flags_q[HIT_HIGH] <= 1'b1;
							end else begin
								py_q             <= rect_q.min_y;
								flags_q[HIT_LOW] <= 1'b1;
							end
						end else if (go_right) begin
							px_q               <= rect_q.max_x;
							flags_q[HIT_RIGHT] <= 1'b1;
						end else begin
							px_q              <= rect_q.min_x;
							flags_q[HIT_LEFT] <= 1'b1;
						end
					end
					idx_q   <= idx_nxt;
					state_q <= last_rect ? ST_FINISH : ST_DIFF;
				end
				ST_FINISH: begin
					if (!out_valid_q || m_axis_tready) begin
						out_x_q     <= px_q;
						out_y_q     <= py_q;
						out_flags_q <= flags_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_W'({out_flags_q, out_y_q, out_x_q});

endmodule
